// File: hdl/goldbach_first_prime_pair_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Goldbach first prime pair block.
// Properties are sampled on the rising edge of clock.
// ----------------------------------------------------------------------------
`ifndef GOLDBACH_FIRST_PRIME_PAIR_TOP_ASSERT_SVH
`define GOLDBACH_FIRST_PRIME_PAIR_TOP_ASSERT_SVH

// This property is not checked while reset is high.
`define GFPP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// This property is also checked while reset is high.
`define GFPP_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: hdl/gfpp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfpp_pkg
// Shared widths, constants and the queued job type of the Goldbach first
// prime pair block.
// ----------------------------------------------------------------------------
package gfpp_pkg;

   // Width of the candidate number.
   localparam int NUM_WIDTH = 16;
   // Width of a prime below half of the number.
   localparam int PRIME_W   = NUM_WIDTH - 1;
   // Width of a trial divisor, which runs one step past the square root.
   localparam int DIV_W     = NUM_WIDTH / 2 + 1;
   // Width of the running square of the trial divisor.
   localparam int SQ_W      = NUM_WIDTH + 1;
   // Width of the bit counter of the remainder unit.
   localparam int CNT_W     = $clog2(NUM_WIDTH);

   // Depth of the queue between the front and the back (a power of two).
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // First prime that is tried.
   localparam int FIRST_PRIME = 2;
   // Smallest even number that can have a pair strictly below half.
   localparam logic [NUM_WIDTH-1:0] MIN_SEARCH_NUM = NUM_WIDTH'(8);

   // One classified request as it waits in the queue.
   typedef struct packed {
      logic [NUM_WIDTH-1:0] number;
      logic                 search;
   } job_type;

endpackage

// File: hdl/goldbach_first_prime_pair_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// goldbach_first_prime_pair_top
// Finds, for each even request, the first prime p strictly below half of the
// number whose partner (number - p) is also prime.
// ----------------------------------------------------------------------------
// Each request gives exactly one response, in request order. Once the back end
// is free, odd numbers and numbers below 8 go from the queue through the idle
// and done states to the output register, with found cleared. The other even
// numbers run a search over p = 2, 3, ... below half; each primality test is
// trial division by d = 2, 3, ... while d*d does not exceed the value, and
// every trial division is one check step followed by a pass of the bit-serial
// remainder unit over all 16 bits of the value. The search time grows with the
// number of candidates p and of trial divisions, and the trial divisions in
// the remainder unit dominate it. Two requests can wait in the queue while a
// search runs, and a finished response waits in the output register without
// blocking the next search.
// ----------------------------------------------------------------------------
module goldbach_first_prime_pair_top import gfpp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [NUM_WIDTH-1:0] req_number,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_found,
   output logic [NUM_WIDTH-1:0] rsp_even_sum,
   output logic [PRIME_W-1:0]   rsp_small_prime,
   output logic [NUM_WIDTH-1:0] rsp_large_prime
);

   logic    job_valid;
   job_type job;
   logic    job_take;

   // Request intake and queue.
   gfpp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_number (req_number),
      .job_valid  (job_valid),
      .job        (job),
      .job_take   (job_take)
   );

   // Search engine and response register.
   gfpp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .job_valid       (job_valid),
      .job             (job),
      .job_take        (job_take),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_found       (rsp_found),
      .rsp_even_sum    (rsp_even_sum),
      .rsp_small_prime (rsp_small_prime),
      .rsp_large_prime (rsp_large_prime)
   );

endmodule

// File: hdl/gfpp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfpp_front
// Accepts requests, marks which ones need a prime pair search and holds
// them in a short queue until the back end takes them.
// ----------------------------------------------------------------------------
module gfpp_front import gfpp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [NUM_WIDTH-1:0] req_number,
   output logic                 job_valid,
   output job_type              job,
   input  logic                 job_take
);

   job_type            queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   job_type            new_job;
   logic               push;

   // Only even numbers large enough for a pair below half are searched.
   always_comb begin
      new_job.number = req_number;
      new_job.search = ~req_number[0] && (req_number >= MIN_SEARCH_NUM);
   end

   assign req_stall = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign job_valid = (count_ff != '0);
   assign job       = queue_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + QPTR_W'(1);
      end
      if (job_take) begin
         rd_ptr_in = rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !job_take) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (!push && job_take) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_job;
      end
   end

endmodule

// File: hdl/gfpp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfpp_back
// Runs the prime pair search for one queued request at a time, with a
// bit-serial remainder unit shared by all trial divisions, and holds the
// response in an output register.
// ----------------------------------------------------------------------------
module gfpp_back import gfpp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   input  job_type              job,
   output logic                 job_take,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_found,
   output logic [NUM_WIDTH-1:0] rsp_even_sum,
   output logic [PRIME_W-1:0]   rsp_small_prime,
   output logic [NUM_WIDTH-1:0] rsp_large_prime
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_LOOP  = 5'b00010,
      ST_CHECK = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [NUM_WIDTH-1:0] num_ff, num_in;
   logic [PRIME_W-1:0]   p_ff, p_in;
   logic [NUM_WIDTH-1:0] val_ff, val_in;
   logic                 second_ff, second_in;
   logic [DIV_W-1:0]     div_ff, div_in;
   logic [SQ_W-1:0]      sq_ff, sq_in;
   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [NUM_WIDTH-1:0] shift_ff, shift_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 hit_ff, hit_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_found_ff;
   logic [NUM_WIDTH-1:0] rsp_even_sum_ff;
   logic [PRIME_W-1:0]   rsp_small_ff;
   logic [NUM_WIDTH-1:0] rsp_large_ff;

   logic [PRIME_W-1:0]   half;
   logic [DIV_W:0]       rem_shift;
   logic [DIV_W-1:0]     rem_next;
   logic                 out_free;
   logic                 rsp_load;

   assign half     = num_ff[NUM_WIDTH-1:1];
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_load = (state_ff == ST_DONE) && out_free;
   assign job_take = (state_ff == ST_IDLE) && job_valid;

   // One restoring step of the remainder unit.
   always_comb begin
      rem_shift = {rem_ff, shift_ff[NUM_WIDTH-1]};
      if (rem_shift >= {1'b0, div_ff}) begin
         rem_next = DIV_W'(rem_shift - {1'b0, div_ff});
      end else begin
         rem_next = rem_shift[DIV_W-1:0];
      end
   end

   // Search sequencer.
   always_comb begin
      state_in  = state_ff;
      num_in    = num_ff;
      p_in      = p_ff;
      val_in    = val_ff;
      second_in = second_ff;
      div_in    = div_ff;
      sq_in     = sq_ff;
      rem_in    = rem_ff;
      shift_in  = shift_ff;
      cnt_in    = cnt_ff;
      hit_in    = hit_ff;
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               num_in = job.number;
               p_in   = PRIME_W'(FIRST_PRIME);
               hit_in = 1'b0;
               state_in = job.search ? ST_LOOP : ST_DONE;
            end
         end
         ST_LOOP: begin
            // Try the next candidate while it stays strictly below half.
            if (p_ff < half) begin
               val_in    = NUM_WIDTH'(p_ff);
               second_in = 1'b0;
               div_in    = DIV_W'(FIRST_PRIME);
               sq_in     = SQ_W'(FIRST_PRIME * FIRST_PRIME);
               state_in  = ST_CHECK;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_CHECK: begin
            if (sq_ff > SQ_W'(val_ff)) begin
               // No divisor up to the square root: the value is prime.
               if (!second_ff) begin
                  val_in    = num_ff - NUM_WIDTH'(p_ff);
                  second_in = 1'b1;
                  div_in    = DIV_W'(FIRST_PRIME);
                  sq_in     = SQ_W'(FIRST_PRIME * FIRST_PRIME);
               end else begin
                  hit_in   = 1'b1;
                  state_in = ST_DONE;
               end
            end else begin
               rem_in   = '0;
               shift_in = val_ff;
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in   = rem_next;
            shift_in = {shift_ff[NUM_WIDTH-2:0], 1'b0};
            cnt_in   = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(NUM_WIDTH - 1)) begin
               if (rem_next == '0) begin
                  // Divisible: move on to the next candidate.
                  p_in     = p_ff + PRIME_W'(1);
                  state_in = ST_LOOP;
               end else begin
                  // (d+1)^2 = d^2 + 2d + 1.
                  div_in   = div_ff + DIV_W'(1);
                  sq_in    = sq_ff + SQ_W'({div_ff, 1'b1});
                  state_in = ST_CHECK;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath and response payload registers.
   always_ff @(posedge clock) begin
      num_ff    <= num_in;
      p_ff      <= p_in;
      val_ff    <= val_in;
      second_ff <= second_in;
      div_ff    <= div_in;
      sq_ff     <= sq_in;
      rem_ff    <= rem_in;
      shift_ff  <= shift_in;
      cnt_ff    <= cnt_in;
      hit_ff    <= hit_in;
      if (rsp_load) begin
         rsp_found_ff    <= hit_ff;
         rsp_even_sum_ff <= num_ff;
         rsp_small_ff    <= hit_ff ? p_ff : '0;
         rsp_large_ff    <= hit_ff ? val_ff : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_even_sum    = rsp_even_sum_ff;
   assign rsp_small_prime = rsp_small_ff;
   assign rsp_large_prime = rsp_large_ff;

endmodule

// File: hdl/gfpp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfpp_checker
// Checks the response port of the Goldbach first prime pair block over time.
// ----------------------------------------------------------------------------
`include "goldbach_first_prime_pair_top_assert.svh"

module gfpp_checker import gfpp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic                 rsp_found,
   input  logic [NUM_WIDTH-1:0] rsp_even_sum,
   input  logic [PRIME_W-1:0]   rsp_small_prime,
   input  logic [NUM_WIDTH-1:0] rsp_large_prime
);

   // A stalled response stays valid and keeps its number and found flag.
   `GFPP_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_even_sum) && $stable(rsp_found), "stalled response changed")

   // A found pair adds up to the number.
   `GFPP_ASSERT(a_pair_sum, rsp_valid && rsp_found |-> (NUM_WIDTH'(rsp_small_prime) + rsp_large_prime) == rsp_even_sum, "prime pair does not add up to the number")

   // A found pair belongs to an even number and sits on both sides of half.
   `GFPP_ASSERT(a_pair_order, rsp_valid && rsp_found |-> !rsp_even_sum[0] && rsp_small_prime >= PRIME_W'(FIRST_PRIME) && rsp_large_prime > NUM_WIDTH'(rsp_small_prime), "found pair out of order")

   // No pair means both primes read as zero.
   `GFPP_ASSERT(a_no_pair, rsp_valid && !rsp_found |-> rsp_small_prime == '0 && rsp_large_prime == '0, "primes not cleared without a pair")

   // Reset leaves no response pending.
   `GFPP_ASSERT_RST(a_reset_idle, reset |=> !rsp_valid, "response valid after reset")

endmodule

bind goldbach_first_prime_pair_top gfpp_checker u_checker (.*);

// File: test/goldbach_first_prime_pair_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// goldbach_first_prime_pair_checker
// Watches both channels of the Goldbach first prime pair block, works out the
// expected pair for every accepted request and compares each response with it.
// ----------------------------------------------------------------------------
module goldbach_first_prime_pair_checker import gfpp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [NUM_WIDTH-1:0] req_number,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic                 rsp_found,
   input  logic [NUM_WIDTH-1:0] rsp_even_sum,
   input  logic [PRIME_W-1:0]   rsp_small_prime,
   input  logic [NUM_WIDTH-1:0] rsp_large_prime,
   output int                   fail_count,
   output int                   outstanding
);

   // The search starts at the smallest prime.
   localparam int unsigned SMALLEST_PRIME = 2;

   typedef struct {
      logic                 found;
      logic [NUM_WIDTH-1:0] even_sum;
      logic [PRIME_W-1:0]   small_prime;
      logic [NUM_WIDTH-1:0] large_prime;
   } pair_result_type;

   // Pairs still owed by the block, oldest first.
   pair_result_type expected_pairs[$];

   // Trial division by every d with d*d not above the value; 0 and 1 are not prime.
   function automatic bit is_prime_num(input int unsigned value);
      int unsigned d;
      if (value < SMALLEST_PRIME) return 1'b0;
      for (d = SMALLEST_PRIME; d * d <= value; d++) begin
         if (value % d == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   // First prime p strictly below half of an even number with number - p prime.
   function automatic pair_result_type first_prime_pair(input logic [NUM_WIDTH-1:0] number);
      pair_result_type result;
      int unsigned     value;
      int unsigned     half;
      int unsigned     p;
      value              = number;
      half               = value >> 1;
      result.found       = 1'b0;
      result.even_sum    = number;
      result.small_prime = '0;
      result.large_prime = '0;
      if (!number[0]) begin
         for (p = SMALLEST_PRIME; p < half && !result.found; p++) begin
            if (is_prime_num(p) && is_prime_num(value - p)) begin
               result.found       = 1'b1;
               result.small_prime = PRIME_W'(p);
               result.large_prime = NUM_WIDTH'(value - p);
            end
         end
      end
      return result;
   endfunction

   // Record each accepted request and check each accepted response.
   always @(posedge clock) begin
      pair_result_type want;
      int              errors;
      errors = 0;
      if (reset) begin
         expected_pairs.delete();
         fail_count  <= 0;
         outstanding <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_pairs.push_back(first_prime_pair(req_number));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_pairs.size() == 0) begin
               $error("Response for number %0d with no request waiting", rsp_even_sum);
               errors++;
            end else begin
               want = expected_pairs.pop_front();
               if (rsp_found !== want.found) begin
                  $error("found (number %0d): expected %0d, actual %0d",
                         want.even_sum, want.found, rsp_found);
                  errors++;
               end
               if (rsp_even_sum !== want.even_sum) begin
                  $error("even_sum: expected %0d, actual %0d", want.even_sum, rsp_even_sum);
                  errors++;
               end
               if (rsp_small_prime !== want.small_prime) begin
                  $error("small_prime (number %0d): expected %0d, actual %0d",
                         want.even_sum, want.small_prime, rsp_small_prime);
                  errors++;
               end
               if (rsp_large_prime !== want.large_prime) begin
                  $error("large_prime (number %0d): expected %0d, actual %0d",
                         want.even_sum, want.large_prime, rsp_large_prime);
                  errors++;
               end
            end
         end
         fail_count  <= fail_count + errors;
         outstanding <= expected_pairs.size();
      end
   end

endmodule

// File: test/goldbach_first_prime_pair_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// goldbach_first_prime_pair_top_tb
// Sends corner numbers and then random numbers to the Goldbach first prime
// pair block under changing idle and stall patterns, and reports the verdict
// from the checker's failure count.
// ----------------------------------------------------------------------------
module goldbach_first_prime_pair_top_tb;
   import gfpp_pkg::*;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_valid  = 1'b0;
   logic                 req_stall;
   logic [NUM_WIDTH-1:0] req_number = '0;
   logic                 rsp_valid;
   logic                 rsp_stall  = 1'b0;
   logic                 rsp_found;
   logic [NUM_WIDTH-1:0] rsp_even_sum;
   logic [PRIME_W-1:0]   rsp_small_prime;
   logic [NUM_WIDTH-1:0] rsp_large_prime;
   int                   fail_count;
   int                   outstanding;

   // Percent of cycles in which the sender idles and the receiver stalls.
   int                   idle_pct  = 0;
   int                   stall_pct = 0;

   // Corner numbers: tiny values, values with no pair under the strict bound,
   // numbers whose first pair needs a long search, and the ends of the range.
   int unsigned corner_numbers [23] = '{
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 12, 98, 992, 3428, 38962,
      32767, 32768, 43690, 21845, 65532, 65534, 65535
   };

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   goldbach_first_prime_pair_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_number      (req_number),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_found       (rsp_found),
      .rsp_even_sum    (rsp_even_sum),
      .rsp_small_prime (rsp_small_prime),
      .rsp_large_prime (rsp_large_prime)
   );

   goldbach_first_prime_pair_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_number      (req_number),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_found       (rsp_found),
      .rsp_even_sum    (rsp_even_sum),
      .rsp_small_prime (rsp_small_prime),
      .rsp_large_prime (rsp_large_prime),
      .fail_count      (fail_count),
      .outstanding     (outstanding)
   );

   // The receiver stalls at random at the current rate.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Offers one request, with random idle cycles first, and waits until it is taken.
   task automatic send_number(input logic [NUM_WIDTH-1:0] number);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid  <= 1'b1;
      req_number <= number;
      do @(posedge clock); while (req_stall);
   endtask

   // Mostly even numbers, many of them small so that searches stay short.
   function automatic logic [NUM_WIDTH-1:0] random_number();
      logic [NUM_WIDTH-1:0] number;
      case ($urandom_range(9))
         0, 1, 2, 3: number = NUM_WIDTH'($urandom_range(1024, 4)) & ~NUM_WIDTH'(1);
         4, 5, 6:    number = NUM_WIDTH'($urandom) & ~NUM_WIDTH'(1);
         7:          number = NUM_WIDTH'($urandom) | NUM_WIDTH'(1);
         default:    number = NUM_WIDTH'($urandom);
      endcase
      return number;
   endfunction

   task automatic set_idling(input int send_rate, input int stall_rate);
      idle_pct  = send_rate;
      stall_pct = stall_rate;
   endtask

   // Stimulus and verdict.
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Corner numbers with no idling.
      set_idling(0, 0);
      foreach (corner_numbers[i]) send_number(NUM_WIDTH'(corner_numbers[i]));

      // Random numbers under each idling pattern.
      repeat (30) send_number(random_number());
      set_idling(74, 0);
      repeat (30) send_number(random_number());
      set_idling(0, 74);
      repeat (30) send_number(random_number());
      set_idling(9, 9);
      repeat (30) send_number(random_number());

      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      if (fail_count == 0 && outstanding == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Ends a run that hangs.
   initial begin
      #200_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

// File: goldbach_first_prime_pair_top.f
+incdir+hdl
hdl/gfpp_pkg.sv
hdl/gfpp_front.sv
hdl/gfpp_back.sv
hdl/goldbach_first_prime_pair_top.sv
hdl/gfpp_checker.sv
test/goldbach_first_prime_pair_checker.sv
test/goldbach_first_prime_pair_top_tb.sv
